/* rtl/core/overlap_track_confirmation_core_assert.svh */
// assertion macros for the overlap track confirmation rtl
`ifndef OVERLAP_TRACK_CONFIRMATION_CORE_ASSERT_SVH
`define OVERLAP_TRACK_CONFIRMATION_CORE_ASSERT_SVH

// condition that holds at every edge out of reset
`define OTC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("otc invariant violated");

// consequence in the same cycle
`define OTC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("otc implication violated");

// consequence in the next cycle
`define OTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("otc next-cycle check violated");

`endif

/* rtl/core/otc_pkg.sv */
// shared constants and types of the overlap track confirmation core
`default_nettype none

package otc_pkg;

    localparam int DEF_MAX_CANDIDATES = 64;
    localparam int DEF_COORD_BITS     = 12;

    localparam int FIELD_W    = 12;
    localparam int ID_W       = 16;
    localparam int COUNT_W    = 4;
    localparam int INDEX_W    = 6;
    localparam int THR_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [THR_W-1:0]   THR_RESET     = 9'd128;
    localparam logic [COUNT_W-1:0] CONFIRM_RESET = 4'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 4'd15;
    localparam logic [COUNT_W-1:0] COUNT_FIRST   = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_CONFIRM   = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        MODE_RECT  = 1'b0,
        MODE_EMPTY = 1'b1
    } mode_t;

    typedef struct packed {
        logic               confirmed;
        logic [ID_W-1:0]    track_id;
        logic [COUNT_W-1:0] hit_count;
        logic               matched;
        logic [INDEX_W-1:0] matched_index;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/otc_det_if.sv */
// detection channel: one rectangle or empty-frame marker per transaction
`default_nettype none

interface otc_det_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [otc_pkg::FIELD_W-1:0] rect_x;
    logic [otc_pkg::FIELD_W-1:0] rect_y;
    logic [otc_pkg::FIELD_W-1:0] rect_width;
    logic [otc_pkg::FIELD_W-1:0] rect_height;
    logic                        last_in_frame;

    modport source (
        output valid, mode, rect_x, rect_y, rect_width, rect_height, last_in_frame,
        input  ready
    );
    modport sink (
        input  valid, mode, rect_x, rect_y, rect_width, rect_height, last_in_frame,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/otc_res_if.sv */
// result channel: one confirmation decision per transaction
`default_nettype none

interface otc_res_if;
    logic                        valid;
    logic                        ready;
    logic                        confirmed;
    logic [otc_pkg::ID_W-1:0]    track_id;
    logic [otc_pkg::COUNT_W-1:0] hit_count;
    logic                        matched;
    logic [otc_pkg::INDEX_W-1:0] matched_index;

    modport source (
        output valid, confirmed, track_id, hit_count, matched, matched_index,
        input  ready
    );
    modport sink (
        input  valid, confirmed, track_id, hit_count, matched, matched_index,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/otc_cand_mem.sv */
// two-bank candidate store, one write and one registered read per cycle
`default_nettype none

module otc_cand_mem #(
    parameter int MAX_CANDIDATES = otc_pkg::DEF_MAX_CANDIDATES,
    parameter int COORD_BITS     = otc_pkg::DEF_COORD_BITS
) (
    input  wire logic                                          clk,
    input  wire logic                                          wr_en,
    input  wire logic [$clog2(MAX_CANDIDATES):0]               wr_addr,
    input  wire logic [4*COORD_BITS+otc_pkg::COUNT_W-1:0]      wr_data,
    input  wire logic                                          rd_en,
    input  wire logic [$clog2(MAX_CANDIDATES):0]               rd_addr,
    output logic      [4*COORD_BITS+otc_pkg::COUNT_W-1:0]      rd_data
);

    localparam int IDX_W   = $clog2(MAX_CANDIDATES);
    localparam int ENTRY_W = 4*COORD_BITS + otc_pkg::COUNT_W;
    localparam int DEPTH   = 2**(IDX_W+1);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/otc_scan.sv */
// best-overlap search over the previous candidate list
`default_nettype none

module otc_scan #(
    parameter int MAX_CANDIDATES = otc_pkg::DEF_MAX_CANDIDATES,
    parameter int COORD_BITS     = otc_pkg::DEF_COORD_BITS
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      start,
    input  wire logic [4*COORD_BITS-1:0]                   query,
    input  wire logic [$clog2(MAX_CANDIDATES+1)-1:0]       prev_size,
    input  wire logic                                      prev_bank,
    output logic                                           rd_en,
    output logic      [$clog2(MAX_CANDIDATES):0]           rd_addr,
    input  wire logic [4*COORD_BITS+otc_pkg::COUNT_W-1:0]  rd_data,
    output logic                                           done,
    output logic      [$clog2(MAX_CANDIDATES)-1:0]         best_idx,
    output logic      [2*COORD_BITS-1:0]                   best_inter,
    output logic      [2*COORD_BITS-1:0]                   best_area,
    output logic      [otc_pkg::COUNT_W-1:0]               best_count
);

    localparam int IDX_W  = $clog2(MAX_CANDIDATES);
    localparam int SIZE_W = $clog2(MAX_CANDIDATES+1);
    localparam int CB     = COORD_BITS;
    localparam int CW     = otc_pkg::COUNT_W;

    function automatic logic [CB-1:0] ovl_len(
        input logic [CB-1:0] a0,
        input logic [CB-1:0] alen,
        input logic [CB-1:0] b0,
        input logic [CB-1:0] blen
    );
        logic [CB:0] lo;
        logic [CB:0] ae;
        logic [CB:0] be;
        logic [CB:0] hi;
        lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
        ae = {1'b0, a0} + {1'b0, alen};
        be = {1'b0, b0} + {1'b0, blen};
        hi = (ae < be) ? ae : be;
        ovl_len = (hi > lo) ? CB'(hi - lo) : '0;
    endfunction

    // issue control
    logic              active_reg, active_next;
    logic              phase_reg, phase_next;
    logic [SIZE_W-1:0] j_reg, j_next;
    logic              issue;

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage payload
    logic [IDX_W-1:0]  idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [CB-1:0]     iw_reg, ih_reg, pw_reg, ph_reg;
    logic [CW-1:0]     cnt2_reg, cnt3_reg, cnt4_reg;
    logic [2*CB-1:0]   inter3_reg, area3_reg, inter4_reg, area4_reg;
    logic              nz3_reg, nz4_reg;
    logic [4*CB-1:0]   cross_new_reg, cross_best_reg;

    // best so far
    logic [IDX_W-1:0]  best_idx_reg;
    logic [2*CB-1:0]   best_inter_reg, best_area_reg;
    logic [CW-1:0]     best_count_reg;

    // unpacked query and candidate
    logic [CB-1:0] qx, qy, qw, qh, px, py, pw, ph;
    logic [CW-1:0] pc;

    assign qx = query[CB-1:0];
    assign qy = query[2*CB-1:CB];
    assign qw = query[3*CB-1:2*CB];
    assign qh = query[4*CB-1:3*CB];
    assign px = rd_data[CB-1:0];
    assign py = rd_data[2*CB-1:CB];
    assign pw = rd_data[3*CB-1:2*CB];
    assign ph = rd_data[4*CB-1:3*CB];
    assign pc = rd_data[4*CB+CW-1:4*CB];

    // a candidate is issued only in phase 0, so the compare sees the updated best
    assign issue   = active_reg && !phase_reg && (j_reg < prev_size);
    assign rd_en   = issue;
    assign rd_addr = {prev_bank, j_reg[IDX_W-1:0]};
    assign done    = active_reg && (j_reg >= prev_size)
                     && !v1_reg && !v2_reg && !v3_reg && !v4_reg;

    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        j_next      = j_reg;
        if (start)
        begin
            active_next = 1'b1;
            phase_next  = 1'b0;
            j_next      = '0;
        end
        else if (active_reg)
        begin
            phase_next = !phase_reg;
            if (issue)
            begin
                j_next = j_reg + SIZE_W'(1);
            end
            if (done)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= 1'b0;
            j_reg      <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            j_reg      <= j_next;
            v1_reg     <= issue;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        idx1_reg <= j_reg[IDX_W-1:0];

        // overlap extents
        iw_reg   <= ovl_len(qx, qw, px, pw);
        ih_reg   <= ovl_len(qy, qh, py, ph);
        pw_reg   <= pw;
        ph_reg   <= ph;
        cnt2_reg <= pc;
        idx2_reg <= idx1_reg;

        // intersection and candidate area
        inter3_reg <= (2*CB)'(iw_reg) * (2*CB)'(ih_reg);
        area3_reg  <= (2*CB)'(pw_reg) * (2*CB)'(ph_reg);
        nz3_reg    <= (iw_reg != '0) && (ih_reg != '0);
        cnt3_reg   <= cnt2_reg;
        idx3_reg   <= idx2_reg;

        // cross products against the best ratio
        cross_new_reg  <= (4*CB)'(inter3_reg) * (4*CB)'(best_area_reg);
        cross_best_reg <= (4*CB)'(best_inter_reg) * (4*CB)'(area3_reg);
        inter4_reg     <= inter3_reg;
        area4_reg      <= area3_reg;
        nz4_reg        <= nz3_reg;
        cnt4_reg       <= cnt3_reg;
        idx4_reg       <= idx3_reg;

        if (start)
        begin
            best_idx_reg   <= '0;
            best_inter_reg <= '0;
            best_area_reg  <= (2*CB)'(1);
            best_count_reg <= '0;
        end
        else if (v4_reg && nz4_reg && (cross_new_reg > cross_best_reg))
        begin
            best_idx_reg   <= idx4_reg;
            best_inter_reg <= inter4_reg;
            best_area_reg  <= area4_reg;
            best_count_reg <= cnt4_reg;
        end
    end

    assign best_idx   = best_idx_reg;
    assign best_inter = best_inter_reg;
    assign best_area  = best_area_reg;
    assign best_count = best_count_reg;

endmodule

`default_nettype wire

/* rtl/core/overlap_track_confirmation_core.sv */
// top level of the overlap track confirmation core
//
// usage
// - det channel: one transaction per detected rectangle (mode 0), or one per
//   frame without detections (mode 1); last_in_frame closes a frame and makes
//   this frame's candidates the list that the next frame is matched against
// - res channel: one transaction per mode 0 rectangle, nothing for mode 1
// - cfg port: cfg_we/cfg_index/cfg_data write overlap_threshold (index 0)
//   and confirm_frames (index 1); write only while the core is idle
// - a rectangle is scanned against the previous list; candidate reads from the
//   candidate store are not issued back to back, since the best-ratio compare
//   feeds back into the next cross product
// - after det acceptance a rectangle passes the scan, threshold, decide and
//   output states; det is ready again in the same cycle that its result appears
//   in the output register, so no new rectangle is accepted before that
// - an empty-frame transaction is handled in the idle state without a scan
// - reset clears both list sizes and the id counter and sets the configuration
//   registers to their defaults; candidate store contents need no clearing
// - a stalled receiver holds the result in the output register; one more
//   rectangle is scanned meanwhile and waits until the register frees up
`default_nettype none

module overlap_track_confirmation_core #(
    parameter int MAX_CANDIDATES = otc_pkg::DEF_MAX_CANDIDATES,
    parameter int COORD_BITS     = otc_pkg::DEF_COORD_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [otc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [otc_pkg::CFG_DATA_W-1:0]   cfg_data,
    otc_det_if.sink                               det,
    otc_res_if.source                             res
);

`include "overlap_track_confirmation_core_assert.svh"

    localparam int IDX_W   = $clog2(MAX_CANDIDATES);
    localparam int SIZE_W  = $clog2(MAX_CANDIDATES+1);
    localparam int CB      = COORD_BITS;
    localparam int CW      = otc_pkg::COUNT_W;
    localparam int ENTRY_W = 4*CB + CW;
    localparam int PROD_W  = 2*CB + otc_pkg::THR_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_THRESH = 5'b00100,
        S_DECIDE = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    function automatic logic [CB-1:0] coord_of(input logic [otc_pkg::FIELD_W-1:0] f);
        logic [otc_pkg::FIELD_W+CB-1:0] ext;
        ext      = {{CB{1'b0}}, f};
        coord_of = ext[CB-1:0];
    endfunction

    // configuration registers
    logic [otc_pkg::THR_W-1:0] thr_reg;
    logic [CW-1:0]             confirm_reg;

    // control state
    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] prev_size_reg, prev_size_next;
    logic [SIZE_W-1:0] cur_size_reg, cur_size_next;
    logic              prev_bank_reg, prev_bank_next;
    logic [otc_pkg::ID_W-1:0] next_id_reg, next_id_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [4*CB-1:0]        query_reg;
    logic                   last_reg;
    logic [PROD_W-1:0]      prod_reg;
    otc_pkg::result_t       result_reg, result_next;
    otc_pkg::result_t       out_data_reg;

    // handshake and decision
    logic              det_accept;
    logic              scan_start;
    logic              scan_done;
    logic              out_load;
    logic              dec_matched;
    logic              dec_confirm;
    logic              dec_store;
    logic              id_bump;
    logic [CW-1:0]     dec_count;
    logic [SIZE_W-1:0] cur_size_fill;
    logic [IDX_W+otc_pkg::INDEX_W-1:0] idx_ext;

    // scan and store wiring
    logic                 rd_en;
    logic [IDX_W:0]       rd_addr;
    logic [ENTRY_W-1:0]   rd_data;
    logic                 wr_en;
    logic [IDX_W:0]       wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic [IDX_W-1:0]     best_idx;
    logic [2*CB-1:0]      best_inter;
    logic [2*CB-1:0]      best_area;
    logic [CW-1:0]        best_count;

    assign det.ready  = (state_reg == S_IDLE);
    assign det_accept = det.valid && det.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= otc_pkg::THR_RESET;
            confirm_reg <= otc_pkg::CONFIRM_RESET;
        end
        else if (cfg_we)
        begin
            case (otc_pkg::cfg_index_t'(cfg_index))
                otc_pkg::CFG_THRESHOLD: thr_reg     <= cfg_data[otc_pkg::THR_W-1:0];
                otc_pkg::CFG_CONFIRM:   confirm_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // candidate store: previous list in prev_bank, current list in the other
    otc_cand_mem #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .COORD_BITS     (COORD_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    otc_scan #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .COORD_BITS     (COORD_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .query      (query_reg),
        .prev_size  (prev_size_reg),
        .prev_bank  (prev_bank_reg),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .done       (scan_done),
        .best_idx   (best_idx),
        .best_inter (best_inter),
        .best_area  (best_area),
        .best_count (best_count)
    );

    // decision: ratio test against the registered threshold product
    assign dec_matched = {1'b0, best_inter, 8'b0} > prod_reg;
    assign dec_confirm = dec_matched && (best_count == confirm_reg);
    always_comb
    begin
        if (!dec_matched)
        begin
            dec_count = otc_pkg::COUNT_FIRST;
        end
        else if (best_count == otc_pkg::COUNT_MAX)
        begin
            dec_count = otc_pkg::COUNT_MAX;
        end
        else
        begin
            dec_count = best_count + CW'(1);
        end
    end

    // a confirmed rectangle is not stored; a full current list drops the rectangle but still reports it
    assign dec_store     = !dec_confirm && (cur_size_reg < SIZE_W'(MAX_CANDIDATES));
    assign cur_size_fill = cur_size_reg + SIZE_W'(dec_store);

    assign wr_en   = (state_reg == S_DECIDE) && dec_store;
    assign wr_addr = {!prev_bank_reg, cur_size_reg[IDX_W-1:0]};
    assign wr_data = {dec_count, query_reg};

    assign idx_ext = {{otc_pkg::INDEX_W{1'b0}}, best_idx};

    always_comb
    begin
        result_next.confirmed     = dec_confirm;
        result_next.track_id      = dec_confirm ? next_id_reg : '0;
        result_next.hit_count     = dec_confirm ? '0 : dec_count;
        result_next.matched       = dec_matched;
        result_next.matched_index = idx_ext[otc_pkg::INDEX_W-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        prev_size_next = prev_size_reg;
        cur_size_next  = cur_size_reg;
        prev_bank_next = prev_bank_reg;
        next_id_next   = next_id_reg;
        scan_start     = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (det_accept)
                begin
                    if (det.mode == otc_pkg::MODE_EMPTY)
                    begin
                        // empty frame drops both lists
                        prev_size_next = '0;
                        cur_size_next  = '0;
                    end
                    else
                    begin
                        scan_start = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_THRESH;
                end
            end
            S_THRESH:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (dec_confirm)
                begin
                    next_id_next = next_id_reg + otc_pkg::ID_W'(1);
                end
                if (last_reg)
                begin
                    // frame end: swap banks instead of copying the list
                    prev_size_next = cur_size_fill;
                    cur_size_next  = '0;
                    prev_bank_next = !prev_bank_reg;
                end
                else
                begin
                    cur_size_next = cur_size_fill;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_size_reg <= '0;
            cur_size_reg  <= '0;
            prev_bank_reg <= 1'b0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_size_reg <= prev_size_next;
            cur_size_reg  <= cur_size_next;
            prev_bank_reg <= prev_bank_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (det_accept)
        begin
            query_reg <= {coord_of(det.rect_height), coord_of(det.rect_width),
                          coord_of(det.rect_y), coord_of(det.rect_x)};
            last_reg  <= det.last_in_frame;
        end
        if (state_reg == S_THRESH)
        begin
            prod_reg <= PROD_W'(thr_reg) * PROD_W'(best_area);
        end
        if (state_reg == S_DECIDE)
        begin
            result_reg <= result_next;
        end
        if (out_load)
        begin
            out_data_reg <= result_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.confirmed     = out_data_reg.confirmed;
    assign res.track_id      = out_data_reg.track_id;
    assign res.hit_count     = out_data_reg.hit_count;
    assign res.matched       = out_data_reg.matched;
    assign res.matched_index = out_data_reg.matched_index;

    // checks
    assign id_bump = (state_reg == S_DECIDE) && dec_confirm;

    `OTC_ASSERT_ALWAYS(a_cur_size_bound, cur_size_reg <= SIZE_W'(MAX_CANDIDATES))
    `OTC_ASSERT_ALWAYS(a_prev_size_bound, prev_size_reg <= SIZE_W'(MAX_CANDIDATES))
    `OTC_ASSERT_IMPLY(a_done_in_scan, scan_done, state_reg == S_SCAN)
    `OTC_ASSERT_NEXT(a_id_step, id_bump, next_id_reg == $past(next_id_reg) + otc_pkg::ID_W'(1))

endmodule

`default_nettype wire
